@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the compensation datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

@@ hdl/bpc_pkg.sv @@
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = 5;

  // Register indexes (word address = 4 * index)
  localparam logic [2:0] REG_SENS       = 3'd0;
  localparam logic [2:0] REG_OFFSET     = 3'd1;
  localparam logic [2:0] REG_SENS_TEMP  = 3'd2;
  localparam logic [2:0] REG_OFF_TEMP   = 3'd3;
  localparam logic [2:0] REG_REF_TEMP   = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE = 3'd5;

  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } bpc_coeff_t;

  // First-order results
  typedef struct packed {
    logic signed [17:0] trel;
    logic signed [34:0] off;
    logic signed [33:0] sens;
    logic        [16:0] t2;
    logic        [23:0] d1;
  } bpc_front_t;

  // After the low-temperature correction
  typedef struct packed {
    logic signed [18:0] trel;
    logic signed [36:0] off;
    logic signed [35:0] sens;
    logic        [23:0] d1;
    logic               low;
  } bpc_corr_t;

endpackage

@@ hdl/bpc_cfg.sv @@
`timescale 1ns / 1ps
module bpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bpc_pkg::bpc_coeff_t           coeff
);

  bpc_pkg::bpc_coeff_t coeff_r, coeff_nxt;
  logic [2:0]          idx;
  logic                wr_en;
  logic [15:0]         rd_word;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    coeff_nxt = coeff_r;
    if (wr_en) begin
      unique case (idx)
        bpc_pkg::REG_SENS:       coeff_nxt.c1 = pwdata[15:0];
        bpc_pkg::REG_OFFSET:     coeff_nxt.c2 = pwdata[15:0];
        bpc_pkg::REG_SENS_TEMP:  coeff_nxt.c3 = pwdata[15:0];
        bpc_pkg::REG_OFF_TEMP:   coeff_nxt.c4 = pwdata[15:0];
        bpc_pkg::REG_REF_TEMP:   coeff_nxt.c5 = pwdata[15:0];
        bpc_pkg::REG_TEMP_SLOPE: coeff_nxt.c6 = pwdata[15:0];
        default:                 coeff_nxt = coeff_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bpc_pkg::REG_SENS:       rd_word = coeff_r.c1;
      bpc_pkg::REG_OFFSET:     rd_word = coeff_r.c2;
      bpc_pkg::REG_SENS_TEMP:  rd_word = coeff_r.c3;
      bpc_pkg::REG_OFF_TEMP:   rd_word = coeff_r.c4;
      bpc_pkg::REG_REF_TEMP:   rd_word = coeff_r.c5;
      bpc_pkg::REG_TEMP_SLOPE: rd_word = coeff_r.c6;
      default:                 rd_word = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  assign prdata = {16'h0000, rd_word};
  assign coeff  = coeff_r;

endmodule

@@ hdl/bpc_front.sv @@
`timescale 1ns / 1ps
module bpc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [23:0]              d1,
  input  logic [23:0]              d2,
  input  bpc_pkg::bpc_coeff_t      coeff,
  output logic                     valid_o,
  output bpc_pkg::bpc_front_t      front_o
);

  // stage 1: temperature difference
  logic signed [24:0] dt_nxt, dt_r;
  logic        [23:0] d1_s1_r;
  logic               v1_r;

  // stage 2: products against dT
  logic signed [40:0] mul_t6_nxt, mul_t6_r;
  logic signed [40:0] mul_off_nxt, mul_off_r;
  logic signed [40:0] mul_sens_nxt, mul_sens_r;
  logic signed [48:0] sq_full;
  logic        [47:0] sq_nxt, sq_r;
  logic        [23:0] d1_s2_r;
  logic               v2_r;

  // stage 3: first-order terms
  bpc_pkg::bpc_front_t front_nxt, front_r;
  logic                v3_r;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, coeff.c5, 8'h00});

  assign mul_t6_nxt   = 41'(dt_r) * 41'($signed({1'b0, coeff.c6}));
  assign mul_off_nxt  = 41'(dt_r) * 41'($signed({1'b0, coeff.c4}));
  assign mul_sens_nxt = 41'(dt_r) * 41'($signed({1'b0, coeff.c3}));
  assign sq_full      = 49'(dt_r) * 49'(dt_r);
  assign sq_nxt       = sq_full[47:0];

  // floor shifts are the upper slices of the two's complement products
  always_comb begin
    front_nxt.trel = $signed(mul_t6_r[40:23]);
    front_nxt.off  = 35'($signed({1'b0, coeff.c2, 16'h0000}))
                   + 35'($signed(mul_off_r[40:7]));
    front_nxt.sens = 34'($signed({1'b0, coeff.c1, 15'h0000}))
                   + 34'($signed(mul_sens_r[40:8]));
    front_nxt.t2   = sq_r[47:31];
    front_nxt.d1   = d1_s2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dt_r       <= dt_nxt;
    d1_s1_r    <= d1;
    mul_t6_r   <= mul_t6_nxt;
    mul_off_r  <= mul_off_nxt;
    mul_sens_r <= mul_sens_nxt;
    sq_r       <= sq_nxt;
    d1_s2_r    <= d1_s1_r;
    front_r    <= front_nxt;
  end

  assign valid_o = v3_r;
  assign front_o = front_r;

endmodule

@@ hdl/bpc_corr.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpc_corr (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  bpc_pkg::bpc_front_t      front_i,
  output logic                     valid_o,
  output bpc_pkg::bpc_corr_t       corr_o
);

  // stage 4: square of the relative temperature
  logic signed [35:0]  sq_full;
  logic        [34:0]  a_nxt, a_r;
  bpc_pkg::bpc_front_t front_r;
  logic                v4_r;

  // stage 5: second-order correction
  logic        [36:0]  five_a;
  logic                low;
  bpc_pkg::bpc_corr_t  corr_nxt, corr_r;
  logic                v5_r;

  assign sq_full = 36'(front_i.trel) * 36'(front_i.trel);
  assign a_nxt   = sq_full[34:0];

  assign five_a = {a_r, 2'b00} + 37'(a_r);
  assign low    = front_r.trel[17];

  always_comb begin
    corr_nxt.d1  = front_r.d1;
    corr_nxt.low = low;
    if (low) begin
      corr_nxt.trel = 19'(front_r.trel) - $signed({2'b00, front_r.t2});
      corr_nxt.off  = 37'(front_r.off)  - $signed({1'b0, five_a[36:1]});
      corr_nxt.sens = 36'(front_r.sens) - $signed({1'b0, five_a[36:2]});
    end else begin
      corr_nxt.trel = 19'(front_r.trel);
      corr_nxt.off  = 37'(front_r.off);
      corr_nxt.sens = 36'(front_r.sens);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= valid_i;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    front_r <= front_i;
    corr_r  <= corr_nxt;
  end

  assign valid_o = v5_r;
  assign corr_o  = corr_r;

  // the correction flag must agree with the sign of the final temperature offset
  `BPC_ASSERT_IMP(a_low_sign, clk, rst_n, valid_o, corr_o.low == corr_o.trel[18])
  `BPC_ASSERT_NXT(a_valid_adv, clk, rst_n, v4_r, valid_o)

endmodule

@@ hdl/bpc_press.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpc_press (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  bpc_pkg::bpc_corr_t       corr_i,
  output logic                     valid_o,
  output logic signed [31:0]       pressure_o,
  output logic signed [19:0]       temperature_o,
  output logic                     low_o
);

  // stage 6: D1 * SENS as two partial products
  logic        [41:0] pp_lo_nxt, pp_lo_r;
  logic signed [42:0] pp_hi_nxt, pp_hi_r;
  bpc_pkg::bpc_corr_t corr6_r;
  logic               v6_r;

  // stage 7: recombine and scale
  logic signed [59:0] prod_full;
  logic signed [38:0] scaled_nxt, scaled_r;
  bpc_pkg::bpc_corr_t corr7_r;
  logic               v7_r;

  // stage 8: subtract offset, output register
  logic signed [39:0] diff;
  logic signed [31:0] press_nxt, press_r;
  logic signed [19:0] temp_nxt, temp_r;
  logic               low_r;
  logic               v8_r;

  assign pp_lo_nxt = 42'(corr_i.d1) * 42'(corr_i.sens[17:0]);
  assign pp_hi_nxt = 43'($signed({1'b0, corr_i.d1})) * 43'($signed(corr_i.sens[35:18]));

  assign prod_full  = (60'(pp_hi_r) <<< 18) + $signed({18'h00000, pp_lo_r});
  assign scaled_nxt = $signed(prod_full[59:21]);

  // result spans 25 signed bits and is sign-extended to 32 bits
  assign diff      = 40'(scaled_r) - 40'(corr7_r.off);
  assign press_nxt = 32'($signed(diff[39:15]));
  assign temp_nxt  = 20'(corr7_r.trel) + bpc_pkg::TEMP_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v6_r <= valid_i;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo_r  <= pp_lo_nxt;
    pp_hi_r  <= pp_hi_nxt;
    corr6_r  <= corr_i;
    scaled_r <= scaled_nxt;
    corr7_r  <= corr6_r;
    press_r  <= press_nxt;
    temp_r   <= temp_nxt;
    low_r    <= corr7_r.low;
  end

  assign valid_o       = v8_r;
  assign pressure_o    = press_r;
  assign temperature_o = temp_r;
  assign low_o         = low_r;

  `BPC_ASSERT_IMP(a_press_range, clk, rst_n, valid_o, (&press_r[31:24]) || !(|press_r[31:24]))

endmodule

@@ hdl/baro_pressure_temp_compensation_unit.sv @@
// Each accepted word passes the front, correction and pressure stages before the out_valid strobe.
// Throughput: one word per cycle; busy is held low and the datapath never stalls.
// Results appear for one cycle on out_valid; the receiver cannot stall them.
// Reset (rst_n low, synchronous) clears every stage valid bit and all six coefficients.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module baro_pressure_temp_compensation_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       start,
  output logic                       busy,
  input  logic [23:0]                in_raw_pressure,
  input  logic [23:0]                in_raw_temperature,
  // result channel
  output logic                       out_valid,
  output logic signed [31:0]         out_pressure_centi_mbar,
  output logic signed [19:0]         out_temperature_centi_deg,
  output logic                       out_low_temp_corrected,
  // configuration (APB)
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  bpc_pkg::bpc_coeff_t coeff;
  bpc_pkg::bpc_front_t front;
  bpc_pkg::bpc_corr_t  corr;
  logic                front_valid;
  logic                corr_valid;
  logic                accept;

  // every stage advances each cycle, so a new word is always taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Calibration words C1..C6; the user must write them only while the pipeline is drained, not enforced here
  bpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeff   (coeff)
  );

  // Stages 1-3: dT, the four products against dT, first-order OFF/SENS/TEMP
  bpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .d1       (in_raw_pressure),
    .d2       (in_raw_temperature),
    .coeff    (coeff),
    .valid_o  (front_valid),
    .front_o  (front)
  );

  // Stages 4-5: second-order correction below 20 C
  bpc_corr u_corr (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (corr_valid),
    .corr_o  (corr)
  );

  // Stages 6-8: split D1*SENS multiply, offset subtract, output register
  bpc_press u_press (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (corr_valid),
    .corr_i        (corr),
    .valid_o       (out_valid),
    .pressure_o    (out_pressure_centi_mbar),
    .temperature_o (out_temperature_centi_deg),
    .low_o         (out_low_temp_corrected)
  );

  // each accepted word yields exactly one strobe on out_valid
  `BPC_ASSERT_IMP(a_latency, clk, rst_n, accept, ##8 out_valid)
  `BPC_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(start, 8))

endmodule
